// ===== sv/sdtq_pkg.sv =====
// Shared types and codes for the sorted delay timer queue.
// No dependencies; every other file but sdtq_ram imports this package.
package sdtq_pkg;

   typedef enum logic [1:0] {
      OP_TICK  = 2'd0,
      OP_DELAY = 2'd1,
      OP_UNTIL = 2'd2,
      OP_QUERY = 2'd3
   } opcode_type;

   typedef struct packed {
      opcode_type  opcode;
      logic [7:0]  task_id;
      logic [31:0] tick_amount;
   } req_type;

   typedef struct packed {
      logic [7:0]  task_id_res;
      logic [31:0] tick_value;
      logic        status;
      logic        last;
   } rsp_type;

   // One queued waiter: task id and wake time.
   typedef struct packed {
      logic [7:0]  id;
      logic [31:0] wake;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // Controller to datapath.
   typedef struct packed {
      logic load;        // capture request, bump tick count on a tick
      logic reply;       // send the immediate or queue-full reply
      logic ptr_init;    // point at the queue tail for an insert
      logic pop;         // release the head entry
      logic flush;       // send the held release as the final one
      logic shift;       // move the examined entry up by one place
      logic place;       // write the new entry and grow the queue
      logic place_above; // write it just above the examined entry
   } cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic is_tick;
      logic immediate;
      logic full;
      logic empty;
      logic match;
      logic later;
      logic ptr_zero;
   } status_type;

endpackage

// ===== sv/sdtq_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module sdtq_ram #(
   parameter int WIDTH = 40,
   parameter int DEPTH = 32
) (
   input  logic                              clock,
   input  logic                              wr_en,
   input  logic [$clog2(DEPTH)-1:0]          wr_addr,
   input  logic [WIDTH-1:0]                  wr_data,
   input  logic [$clog2(DEPTH)-1:0]          rd_addr,
   output logic [WIDTH-1:0]                  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/sdtq_datapath.sv =====
// Datapath: tick counter, circular sorted wait queue in RAM, scan pointer, result register.
// Depends on sdtq_pkg and sdtq_ram.
module sdtq_datapath import sdtq_pkg::*; #(
   parameter int QUEUE_DEPTH = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  req_type    req_item,
   input  cmd_type    cmd,
   output status_type status,
   output logic       rsp_strobe,
   output rsp_type    rsp_item
);

   localparam int AW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [AW:0] DEPTH_W = (AW + 1)'(QUEUE_DEPTH);

   logic [31:0]   tick_ff, tick_in;
   logic [AW-1:0] head_ff, head_in;
   logic [CW-1:0] count_ff, count_in;
   logic [AW-1:0] ptr_ff, ptr_in;
   req_type       req_ff, req_in;
   logic [31:0]   wake_ff, wake_in;
   logic          pend_valid_ff, pend_valid_in;
   logic [7:0]    pend_id_ff, pend_id_in;
   logic          rsp_strobe_ff, rsp_strobe_in;
   rsp_type       rsp_ff, rsp_in;

   logic          is_tick, immediate, full, empty;
   logic [AW:0]   rd_offs, wr_offs;
   logic [AW-1:0] rd_addr, wr_addr;
   logic          wr_en;
   entry_type     wr_entry, rd_entry;
   logic [ENTRY_W-1:0] rd_bits;

   // Map a logical queue position onto the circular buffer.
   function automatic logic [AW-1:0] phys_addr(input logic [AW-1:0] base,
                                                input logic [AW:0] offs);
      logic [AW:0] sum;
      begin
         sum = {1'b0, base} + offs;
         if (sum >= DEPTH_W) begin
            sum = sum - DEPTH_W;
         end
         return sum[AW-1:0];
      end
   endfunction

   assign is_tick = (req_ff.opcode == OP_TICK);
   assign full    = (count_ff == CW'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);

   always_comb begin
      unique case (req_ff.opcode)
         OP_TICK:  immediate = 1'b0;
         OP_DELAY: immediate = (req_ff.tick_amount == 32'd0);
         OP_UNTIL: immediate = (req_ff.tick_amount <= tick_ff);
         OP_QUERY: immediate = 1'b1;
         default:  immediate = 1'b1;
      endcase
   end

   assign rd_entry = entry_type'(rd_bits);

   assign status.is_tick   = is_tick;
   assign status.immediate = immediate;
   assign status.full      = full;
   assign status.empty     = empty;
   assign status.match     = (rd_entry.wake == tick_ff);
   assign status.later     = (rd_entry.wake > wake_ff);
   assign status.ptr_zero  = (ptr_ff == '0);

   always_comb begin
      tick_in       = tick_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      ptr_in        = ptr_ff;
      req_in        = req_ff;
      wake_in       = wake_ff;
      pend_valid_in = pend_valid_ff;
      pend_id_in    = pend_id_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;

      if (cmd.load) begin
         req_in  = req_item;
         wake_in = (req_item.opcode == OP_DELAY) ? (tick_ff + req_item.tick_amount)
                                                 : req_item.tick_amount;
         if (req_item.opcode == OP_TICK) begin
            tick_in = tick_ff + 32'd1;
         end
      end

      if (cmd.ptr_init) begin
         ptr_in = empty ? '0 : AW'(count_ff - CW'(1));
      end
      if (cmd.shift && (ptr_ff != '0)) begin
         ptr_in = ptr_ff - AW'(1);
      end

      if (cmd.reply) begin
         rsp_strobe_in      = 1'b1;
         rsp_in.task_id_res = req_ff.task_id;
         rsp_in.tick_value  = tick_ff;
         rsp_in.status      = full & ~immediate;
         rsp_in.last        = 1'b1;
      end

      if (cmd.pop) begin
         head_in       = (head_ff == AW'(QUEUE_DEPTH - 1)) ? '0 : head_ff + AW'(1);
         count_in      = count_ff - CW'(1);
         pend_valid_in = 1'b1;
         pend_id_in    = rd_entry.id;
         // Release the held entry now that another one follows it.
         rsp_strobe_in      = pend_valid_ff;
         rsp_in.task_id_res = pend_id_ff;
         rsp_in.tick_value  = tick_ff;
         rsp_in.status      = 1'b0;
         rsp_in.last        = 1'b0;
      end

      if (cmd.flush) begin
         pend_valid_in      = 1'b0;
         rsp_strobe_in      = pend_valid_ff;
         rsp_in.task_id_res = pend_id_ff;
         rsp_in.tick_value  = tick_ff;
         rsp_in.status      = 1'b0;
         rsp_in.last        = 1'b1;
      end

      if (cmd.place) begin
         count_in = count_ff + CW'(1);
      end
   end

   // Release reads follow the head; insert reads walk down from the tail.
   assign rd_offs = is_tick ? '0 : {1'b0, ptr_in};
   assign rd_addr = phys_addr(head_in, rd_offs);

   always_comb begin
      wr_en    = cmd.shift | cmd.place;
      wr_offs  = (cmd.shift | cmd.place_above) ? ({1'b0, ptr_ff} + (AW + 1)'(1))
                                               : {1'b0, ptr_ff};
      wr_entry = cmd.shift ? rd_entry : entry_type'{id: req_ff.task_id, wake: wake_ff};
   end

   assign wr_addr = phys_addr(head_ff, wr_offs);

   sdtq_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_addr (rd_addr),
      .rd_data (rd_bits)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff       <= '0;
         head_ff       <= '0;
         count_ff      <= '0;
         pend_valid_ff <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         tick_ff       <= tick_in;
         head_ff       <= head_in;
         count_ff      <= count_in;
         pend_valid_ff <= pend_valid_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff     <= ptr_in;
      req_ff     <= req_in;
      wake_ff    <= wake_in;
      pend_id_ff <= pend_id_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(QUEUE_DEPTH))
      else $error("queue count above depth");

   a_no_place_full: assert property (@(posedge clock) disable iff (reset)
      cmd.place |-> !full)
      else $error("insert into a full queue");

   a_release_chain: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe_ff && !rsp_ff.last) |=> rsp_strobe_ff)
      else $error("non-final release not followed by another result");

   a_pend_on_tick: assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff |-> is_tick)
      else $error("held release outside a tick");
`endif

endmodule

// ===== sv/sdtq_ctrl.sv =====
// Controller state machine: sequences decode, head release and tail-first sorted insert.
// Depends on sdtq_pkg.
module sdtq_ctrl import sdtq_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  status_type status,
   output cmd_type    cmd,
   output logic       busy
);

   typedef enum logic [2:0] {
      IDLE,
      DECIDE,
      REL_CHK,
      INS_CHK,
      INS_FIN
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = DECIDE;
            end
         end
         DECIDE: begin
            priority if (status.is_tick) begin
               state_in = status.empty ? IDLE : REL_CHK;
            end else if (status.immediate || status.full) begin
               cmd.reply = 1'b1;
               state_in  = IDLE;
            end else begin
               cmd.ptr_init = 1'b1;
               state_in     = status.empty ? INS_FIN : INS_CHK;
            end
         end
         REL_CHK: begin
            if (!status.empty && status.match) begin
               cmd.pop = 1'b1;
            end else begin
               cmd.flush = 1'b1;
               state_in  = IDLE;
            end
         end
         INS_CHK: begin
            if (status.later) begin
               cmd.shift = 1'b1;
               // At the bottom of the queue the new entry goes in place zero.
               if (status.ptr_zero) begin
                  state_in = INS_FIN;
               end
            end else begin
               cmd.place       = 1'b1;
               cmd.place_above = 1'b1;
               state_in        = IDLE;
            end
         end
         INS_FIN: begin
            cmd.place = 1'b1;
            state_in  = IDLE;
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         busy_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         busy_ff  <= (state_in != IDLE);
      end
   end

   assign busy = busy_ff;

`ifndef ASSERT_OFF
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy_ff) |=> busy_ff)
      else $error("request transfer did not raise busy");

   a_idle_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == IDLE) |-> !busy_ff)
      else $error("busy while idle");

   a_insert_ok: assert property (@(posedge clock) disable iff (reset)
      (state_ff == DECIDE && !status.is_tick && !status.immediate && !status.full)
      |=> (state_ff == INS_CHK || state_ff == INS_FIN))
      else $error("insert not started");
`endif

endmodule

// ===== sv/sorted_delay_timer_queue.sv =====
// Top level of the sorted delay timer queue: controller plus datapath.
// Depends on sdtq_pkg, sdtq_ctrl, sdtq_datapath (and through it sdtq_ram).
//
//   channel   ports                        transfer
//   request   start, busy, req_item        start high while busy low
//   result    rsp_strobe, rsp_item         every cycle rsp_strobe is high
//
// A query, an immediate reply or a queue-full reply passes through DECIDE back to IDLE;
// its result is registered in DECIDE. A tick pops each due entry in turn in REL_CHK,
// one result per cycle, and flushes the last held one (an empty queue skips REL_CHK).
// An insert walks down from the tail in INS_CHK and moves each entry with a later wake
// time up one place, as the queue RAM has a single read port. Reset clears the tick
// count and empties the queue. Results are never stalled by the receiver.
module sorted_delay_timer_queue import sdtq_pkg::*; #(
   parameter int QUEUE_DEPTH = 32
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  req_type req_item,
   output logic    busy,
   output logic    rsp_strobe,
   output rsp_type rsp_item
);

   cmd_type    cmd;
   status_type status;

   sdtq_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .cmd    (cmd),
      .busy   (busy)
   );

   sdtq_datapath #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_item   (req_item),
      .cmd        (cmd),
      .status     (status),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

endmodule

// ===== test/tb_sorted_delay_timer_queue.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for sorted_delay_timer_queue: predicts every reply and release.
// Depends on sdtq_pkg and the sorted_delay_timer_queue RTL.
module tb_sorted_delay_timer_queue;
   import sdtq_pkg::*;

   localparam int QUEUE_DEPTH  = 32;
   localparam int RANDOM_ITEMS = 150;
   localparam int CYCLE_LIMIT  = 200000;

   // Predicts the tick count, the sorted wait list and the replies each request causes.
   class timer_queue_tracker;
      logic [31:0] tick_count;
      entry_type   waiters[$];
      rsp_type     pending_replies[$];
      int          errors;

      function new();
         tick_count = '0;
         errors     = 0;
      endfunction

      function void push_reply(logic [7:0] id, logic status, logic last);
         pending_replies.push_back('{task_id_res: id, tick_value: tick_count,
                                     status: status, last: last});
      endfunction

      function void insert_waiter(logic [7:0] id, logic [31:0] wake);
         int pos;
         pos = 0;
         if (waiters.size() >= QUEUE_DEPTH) begin
            push_reply(id, 1'b1, 1'b1);
            return;
         end
         while (pos < waiters.size() && waiters[pos].wake <= wake)
            pos++;
         waiters.insert(pos, '{id: id, wake: wake});
      endfunction

      function void note_request(req_type req);
         entry_type head;
         case (req.opcode)
            OP_TICK: begin
               tick_count = tick_count + 1;
               while (waiters.size() > 0 && waiters[0].wake == tick_count) begin
                  head = waiters.pop_front();
                  push_reply(head.id, 1'b0,
                             !(waiters.size() > 0 && waiters[0].wake == tick_count));
               end
            end
            OP_DELAY: begin
               if (req.tick_amount == 0)
                  push_reply(req.task_id, 1'b0, 1'b1);
               else
                  insert_waiter(req.task_id, tick_count + req.tick_amount);
            end
            OP_UNTIL: begin
               if (req.tick_amount <= tick_count)
                  push_reply(req.task_id, 1'b0, 1'b1);
               else
                  insert_waiter(req.task_id, req.tick_amount);
            end
            default: push_reply(req.task_id, 1'b0, 1'b1);
         endcase
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (pending_replies.size() == 0) begin
            $error("unexpected result: task_id_res %0d tick_value %0d",
                   got.task_id_res, got.tick_value);
            errors++;
            return;
         end
         want = pending_replies.pop_front();
         if (got.task_id_res !== want.task_id_res) begin
            $error("task_id_res: expected %0d, got %0d", want.task_id_res, got.task_id_res);
            errors++;
         end
         if (got.tick_value !== want.tick_value) begin
            $error("tick_value: expected %0d, got %0d", want.tick_value, got.tick_value);
            errors++;
         end
         if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            errors++;
         end
         if (got.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, got.last);
            errors++;
         end
      endfunction

      function int pending();
         return pending_replies.size();
      endfunction

      function int free_slots();
         return QUEUE_DEPTH - waiters.size();
      endfunction
   endclass

   logic    clock;
   logic    reset;
   logic    start;
   req_type req_item;
   logic    busy;
   logic    rsp_strobe;
   rsp_type rsp_item;

   timer_queue_tracker tracker = new();
   int items_sent;
   int cycle_count;
   bit gaps_on;
   int big_inserts_left;

   sorted_delay_timer_queue #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_item  (req_item),
      .busy      (busy),
      .rsp_strobe(rsp_strobe),
      .rsp_item  (rsp_item)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(posedge clock) begin
      if (!reset && rsp_strobe === 1'b1)
         tracker.check_result(rsp_item);
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("DONE: errors detected");
      $finish;
   end

   function automatic logic [7:0] rand_id();
      return 8'($urandom_range(0, 255));
   endfunction

   // Hold the request until transferred, then, with gaps on, sometimes idle for a random gap.
   task automatic send_item(input opcode_type op, input logic [7:0] id,
                            input logic [31:0] amt);
      req_type item;
      int      pick;
      int      gap;
      item     = '{opcode: op, task_id: id, tick_amount: amt};
      req_item <= item;
      start    <= 1'b1;
      do @(posedge clock); while (busy !== 1'b0);
      tracker.note_request(item);
      items_sent++;
      gap  = 0;
      pick = $urandom_range(0, 99);
      if (gaps_on) begin
         if (pick >= 90)
            gap = $urandom_range(8, 30);
         else if (pick >= 55)
            gap = $urandom_range(1, 3);
      end
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      @(posedge clock);
      while (tracker.pending() != 0)
         @(posedge clock);
   endtask

   // Fill every free slot, then push one or two inserts into the full queue.
   task automatic fill_queue(input int spread);
      while (tracker.free_slots() > 0)
         send_item(OP_DELAY, rand_id(), $urandom_range(1, spread));
      repeat ($urandom_range(1, 2))
         send_item(OP_DELAY, rand_id(), $urandom_range(1, spread));
   endtask

   initial begin
      int random_base;
      int kind;
      int sel;
      int n;
      bit first_burst;

      reset            = 1'b1;
      start            = 1'b0;
      req_item         = '0;
      items_sent       = 0;
      gaps_on          = 1'b1;
      big_inserts_left = 3;
      first_burst      = 1'b1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed: immediate replies, equal wake times, ordered release.
      send_item(OP_QUERY, 8'h00, 32'h0000_0000);
      send_item(OP_TICK,  8'hFF, 32'h0000_0000);   // nothing queued
      send_item(OP_DELAY, 8'hFF, 32'h0000_0000);   // zero delay
      send_item(OP_UNTIL, 8'h01, 32'h0000_0000);   // deadline passed
      send_item(OP_UNTIL, 8'h02, 32'h0000_0001);   // deadline equals count
      send_item(OP_DELAY, 8'h10, 32'h0000_0001);
      send_item(OP_UNTIL, 8'h11, 32'h0000_0002);
      send_item(OP_DELAY, 8'h12, 32'h0000_0003);
      send_item(OP_DELAY, 8'h13, 32'h0000_0002);
      send_item(OP_DELAY, 8'h14, 32'h0000_0001);   // equal wake goes behind
      send_item(OP_QUERY, 8'hAA, 32'hFFFF_FFFF);
      send_item(OP_TICK,  8'h55, 32'hFFFF_FFFF);   // releases three
      send_item(OP_TICK,  8'h00, 32'h0000_0000);
      send_item(OP_TICK,  8'h00, 32'h0000_0000);
      send_item(OP_TICK,  8'h00, 32'h0000_0000);   // nothing due

      random_base = items_sent;
      while (items_sent - random_base < RANDOM_ITEMS) begin
         gaps_on = ($urandom_range(0, 9) >= 3);
         kind    = first_burst ? 70 : $urandom_range(0, 99);
         first_burst = 1'b0;
         if (kind < 65) begin
            n = $urandom_range(1, 10);
            for (int i = 0; i < n; i++) begin
               sel = $urandom_range(0, 9);
               if (sel < 5)
                  send_item(OP_DELAY, rand_id(), $urandom_range(1, 6));
               else if (sel < 8)
                  send_item(OP_UNTIL, rand_id(),
                            tracker.tick_count + $urandom_range(1, 6));
               else if (sel == 8)
                  send_item(OP_UNTIL, rand_id(),
                            $urandom_range(0, tracker.tick_count));
               else
                  send_item(OP_QUERY, rand_id(), $urandom);
            end
            repeat (7)
               send_item(OP_TICK, rand_id(), $urandom);
         end else if (kind < 77) begin
            fill_queue($urandom_range(1, 3));
            repeat (4)
               send_item(OP_TICK, rand_id(), $urandom);
         end else begin
            repeat ($urandom_range(1, 5)) begin
               sel = $urandom_range(0, 9);
               if (sel == 9 && big_inserts_left > 0 && tracker.free_slots() > 8) begin
                  // Far wake time: parks at the tail for the rest of the run.
                  big_inserts_left--;
                  if ($urandom_range(0, 1))
                     send_item(OP_UNTIL, rand_id(), $urandom | 32'h8000_0000);
                  else
                     send_item(OP_DELAY, rand_id(),
                               $urandom_range(32'h4000_0000, 32'h7FFF_FFFF));
               end else if (sel < 4)
                  send_item(OP_TICK, rand_id(), $urandom);
               else if (sel < 7)
                  send_item(OP_QUERY, rand_id(), $urandom);
               else if (sel == 7)
                  send_item(OP_UNTIL, rand_id(),
                            $urandom_range(0, tracker.tick_count));
               else
                  send_item(OP_DELAY, rand_id(), 32'h0000_0000);
            end
         end
         if ($urandom_range(0, 9) == 0)
            wait_drained();
      end

      // Wrapped delay lands below the count and blocks the queue from here on.
      gaps_on = 1'b1;
      wait_drained();
      send_item(OP_UNTIL, 8'hFE, 32'hFFFF_FFFF);
      send_item(OP_DELAY, 8'hFD, 32'hFFFF_FFFF);
      send_item(OP_DELAY, 8'h21, 32'h0000_0001);
      repeat (3)
         send_item(OP_TICK, rand_id(), $urandom);
      fill_queue(4);
      send_item(OP_QUERY, 8'h7F, 32'h0000_0000);
      send_item(OP_TICK,  8'h80, 32'h0000_0000);

      wait_drained();
      repeat (QUEUE_DEPTH + 8) @(posedge clock);
      if (tracker.errors == 0 && tracker.pending() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

// ===== sim.f =====
sv/sdtq_pkg.sv
sv/sdtq_ram.sv
sv/sdtq_datapath.sv
sv/sdtq_ctrl.sv
sv/sorted_delay_timer_queue.sv
test/tb_sorted_delay_timer_queue.sv
